FILE: rtl/pid_controller_antiwindup_core_assert.svh
// ------------------------------------------------------------------------------------------
// PID controller assertion macros
// Concurrent check macros, included by the core top level, the one file that asserts.
// ------------------------------------------------------------------------------------------
`ifndef PID_CONTROLLER_ANTIWINDUP_CORE_ASSERT_SVH
`define PID_CONTROLLER_ANTIWINDUP_CORE_ASSERT_SVH

// same-cycle implication
`define PIDAW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication check failed");

// next-cycle implication
`define PIDAW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication check failed");

`endif

FILE: rtl/pidaw_pkg.sv
// ------------------------------------------------------------------------------------------
// PID controller package
// Payload types, request and status codes, register indexes and datapath commands.
// ------------------------------------------------------------------------------------------
package pidaw_pkg;

	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] REQ_COMPUTE  = 2'd0;
	localparam logic [1:0] REQ_CLR_INT  = 2'd1;
	localparam logic [1:0] REQ_LOOP_ON  = 2'd2;
	localparam logic [1:0] REQ_LOOP_OFF = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OFF       = 2'd1;
	localparam logic [1:0] ST_UNCHANGED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAX = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MS = 3'd5;

	localparam logic [31:0]        GAIN_P_RST    = 32'd65536;
	localparam logic signed [31:0] DRIVE_MIN_RST = 32'sh8000_0000;
	localparam logic signed [31:0] DRIVE_MAX_RST = 32'sh7fff_ffff;
	localparam logic [15:0]        PERIOD_RST    = 16'd100;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [31:0]        now_ms;
		logic signed [31:0] measured;
		logic signed [31:0] target;
	} pid_in_t;

	typedef struct packed {
		logic signed [31:0] drive;
		logic [1:0]         status;
	} pid_out_t;

	typedef enum logic [3:0] {
		CMD_IDLE,
		CMD_CLR_INT,
		CMD_LOOP_OFF,
		CMD_MUL_P,
		CMD_FIX_P,
		CMD_MUL_I,
		CMD_FIX_I,
		CMD_MUL_D,
		CMD_FIX_D,
		CMD_COMMIT,
		CMD_LOOP_ON
	} cmd_op_t;

	typedef struct packed {
		logic    load;
		cmd_op_t op;
	} pidaw_cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       loop_on;
		logic       too_early;
	} pidaw_stat_t;

endpackage

FILE: rtl/pidaw_datapath.sv
// ------------------------------------------------------------------------------------------
// PID controller datapath
// Configuration registers, loop state and one shared 32x32 multiplier with Q16.16 rescale.
// ------------------------------------------------------------------------------------------
module pidaw_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [pidaw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                       cfg_data,
	input  pidaw_pkg::pid_in_t                in_data,
	input  pidaw_pkg::pidaw_cmd_t             cmd,
	output pidaw_pkg::pidaw_stat_t            stat,
	output logic signed [31:0]                held_drive
);
	import pidaw_pkg::*;

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] abs32(input logic signed [31:0] x);
		logic [31:0] r;
		r = x[31] ? (~x + 32'd1) : x;
		return r;
	endfunction

	function automatic logic signed [31:0] fix_prod(input logic [63:0] prod, input logic neg);
		logic [47:0]        q;
		logic signed [31:0] r;
		q = prod[63:16];
		if (neg) begin
			if (q[47:32] != '0 || (q[31] && q[30:0] != '0)) begin
				r = 32'sh8000_0000;
			end else begin
				r = -$signed(q[31:0]);
			end
		end else begin
			if (q[47:31] != '0) begin
				r = 32'sh7fff_ffff;
			end else begin
				r = $signed(q[31:0]);
			end
		end
		return r;
	endfunction

	logic [31:0]        gain_p_q, gain_i_q, gain_d_q;
	logic signed [31:0] drive_min_q, drive_max_q;
	logic [15:0]        period_q;

	logic               loop_on_q;
	logic signed [31:0] integral_q, prev_p_q, held_q;
	logic [31:0]        last_q;

	logic [1:0]         req_q;
	logic [31:0]        now_q;
	logic signed [31:0] err_q, p_q, inc_q, diff_q, d_q, isum_q;
	logic [63:0]        product_q;
	logic               neg_q;

	logic [31:0]        mul_a, mul_b, elapsed;
	logic               mul_neg;
	logic signed [32:0] in_diff, pd_diff, isum_raw, isum_back, min33, max33;
	logic signed [31:0] isum_clamped, fixed, drive_new, integral_new;
	logic signed [33:0] drv_sum, min34, max34;
	logic               clamped;

	assign in_diff = {in_data.target[31], in_data.target}
		- {in_data.measured[31], in_data.measured};
	assign pd_diff = {p_q[31], p_q} - {prev_p_q[31], prev_p_q};
	assign fixed   = fix_prod(product_q, neg_q);
	assign elapsed = now_q - last_q;

	always_comb begin
		case (cmd.op)
			CMD_MUL_I: begin
				mul_a   = gain_i_q;
				mul_b   = abs32(p_q);
				mul_neg = p_q[31];
			end
			CMD_MUL_D: begin
				mul_a   = gain_d_q;
				mul_b   = abs32(diff_q);
				mul_neg = diff_q[31];
			end
			default: begin
				mul_a   = gain_p_q;
				mul_b   = abs32(err_q);
				mul_neg = err_q[31];
			end
		endcase
	end

	always_comb begin
		min33    = {drive_min_q[31], drive_min_q};
		max33    = {drive_max_q[31], drive_max_q};
		isum_raw = {integral_q[31], integral_q} + {inc_q[31], inc_q};
		if (isum_raw > max33) begin
			isum_clamped = drive_max_q;
		end else if (isum_raw < min33) begin
			isum_clamped = drive_min_q;
		end else begin
			isum_clamped = isum_raw[31:0];
		end
	end

	always_comb begin
		min34   = {{2{drive_min_q[31]}}, drive_min_q};
		max34   = {{2{drive_max_q[31]}}, drive_max_q};
		drv_sum = {{2{p_q[31]}}, p_q} + {{2{isum_q[31]}}, isum_q} + {{2{d_q[31]}}, d_q};
		clamped = 1'b1;
		if (drv_sum > max34) begin
			drive_new = drive_max_q;
		end else if (drv_sum < min34) begin
			drive_new = drive_min_q;
		end else begin
			drive_new = drv_sum[31:0];
			clamped   = 1'b0;
		end
		isum_back    = {isum_q[31], isum_q} - {inc_q[31], inc_q};
		integral_new = clamped ? sat33(isum_back) : isum_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= GAIN_P_RST;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			drive_min_q <= DRIVE_MIN_RST;
			drive_max_q <= DRIVE_MAX_RST;
			period_q    <= PERIOD_RST;
			loop_on_q   <= 1'b0;
			integral_q  <= '0;
			prev_p_q    <= '0;
			held_q      <= '0;
			last_q      <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_GAIN_P:    gain_p_q    <= cfg_data;
					CFG_GAIN_I:    gain_i_q    <= cfg_data;
					CFG_GAIN_D:    gain_d_q    <= cfg_data;
					CFG_DRIVE_MIN: drive_min_q <= $signed(cfg_data);
					CFG_DRIVE_MAX: drive_max_q <= $signed(cfg_data);
					CFG_PERIOD_MS: period_q    <= cfg_data[15:0];
					default: ;
				endcase
			end
			case (cmd.op)
				CMD_CLR_INT:  integral_q <= '0;
				CMD_LOOP_OFF: loop_on_q  <= 1'b0;
				CMD_LOOP_ON: begin
					integral_q <= '0;
					prev_p_q   <= p_q;
					last_q     <= now_q;
					loop_on_q  <= 1'b1;
				end
				CMD_COMMIT: begin
					integral_q <= integral_new;
					held_q     <= drive_new;
					prev_p_q   <= p_q;
					last_q     <= now_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_data.req_type;
			now_q <= in_data.now_ms;
			err_q <= sat33(in_diff);
		end
		case (cmd.op) inside
			CMD_MUL_P, CMD_MUL_I, CMD_MUL_D: begin
				product_q <= mul_a * mul_b;
				neg_q     <= mul_neg;
			end
			default: ;
		endcase
		case (cmd.op)
			CMD_FIX_P: p_q    <= fixed;
			CMD_MUL_I: diff_q <= sat33(pd_diff);
			CMD_FIX_I: inc_q  <= fixed;
			CMD_MUL_D: isum_q <= isum_clamped;
			CMD_FIX_D: d_q    <= fixed;
			default: ;
		endcase
	end

	assign stat.req_type  = req_q;
	assign stat.loop_on   = loop_on_q;
	assign stat.too_early = (elapsed < {16'd0, period_q});
	assign held_drive     = held_q;

endmodule

FILE: rtl/pidaw_ctrl.sv
// ------------------------------------------------------------------------------------------
// PID controller sequencer
// Decodes each request and steps the datapath through the multiply and commit sequence.
// ------------------------------------------------------------------------------------------
module pidaw_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   out_free,
	input  pidaw_pkg::pidaw_stat_t stat,
	output pidaw_pkg::pidaw_cmd_t  cmd,
	output logic                   done,
	output logic [1:0]             done_status
);
	import pidaw_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_MUL_P,
		S_FIX_P,
		S_MUL_I,
		S_FIX_I,
		S_MUL_D,
		S_FIX_D,
		S_COMMIT,
		S_LOOP_ON,
		S_FINISH
	} state_t;

	state_t     state_q;
	logic [1:0] status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					status_q <= ST_OK;
					state_q  <= S_FINISH;
					unique case (stat.req_type)
						REQ_COMPUTE: begin
							if (!stat.loop_on) begin
								status_q <= ST_OFF;
							end else if (stat.too_early) begin
								status_q <= ST_UNCHANGED;
							end else begin
								state_q <= S_MUL_P;
							end
						end
						REQ_LOOP_ON: begin
							if (stat.loop_on) status_q <= ST_UNCHANGED;
							else state_q <= S_MUL_P;
						end
						REQ_LOOP_OFF: begin
							if (!stat.loop_on) status_q <= ST_UNCHANGED;
						end
						default: ;
					endcase
				end
				S_MUL_P:   state_q <= S_FIX_P;
				S_FIX_P:   state_q <= (stat.req_type == REQ_LOOP_ON) ? S_LOOP_ON : S_MUL_I;
				S_MUL_I:   state_q <= S_FIX_I;
				S_FIX_I:   state_q <= S_MUL_D;
				S_MUL_D:   state_q <= S_FIX_D;
				S_FIX_D:   state_q <= S_COMMIT;
				S_COMMIT:  state_q <= S_FINISH;
				S_LOOP_ON: state_q <= S_FINISH;
				S_FINISH: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.load = in_valid && (state_q == S_IDLE);
		cmd.op   = CMD_IDLE;
		case (state_q)
			S_DECIDE: begin
				if (stat.req_type == REQ_CLR_INT) begin
					cmd.op = CMD_CLR_INT;
				end else if (stat.req_type == REQ_LOOP_OFF && stat.loop_on) begin
					cmd.op = CMD_LOOP_OFF;
				end
			end
			S_MUL_P:   cmd.op = CMD_MUL_P;
			S_FIX_P:   cmd.op = CMD_FIX_P;
			S_MUL_I:   cmd.op = CMD_MUL_I;
			S_FIX_I:   cmd.op = CMD_FIX_I;
			S_MUL_D:   cmd.op = CMD_MUL_D;
			S_FIX_D:   cmd.op = CMD_FIX_D;
			S_COMMIT:  cmd.op = CMD_COMMIT;
			S_LOOP_ON: cmd.op = CMD_LOOP_ON;
			default: ;
		endcase
	end

	assign in_ready    = (state_q == S_IDLE);
	assign done        = (state_q == S_FINISH) && out_free;
	assign done_status = status_q;

endmodule

FILE: rtl/pid_controller_antiwindup_core.sv
// ------------------------------------------------------------------------------------------
// PID controller with anti-windup
// Q16.16 PID regulator: sequencer, datapath and an output register.
// ------------------------------------------------------------------------------------------
// A compute request that updates the drive steps P, the integral increment and D one after
// another through the single shared 32x32 multiplier, each as a multiply then a rescale
// step, followed by a commit, before the result is offered. A mode-on request runs only
// one multiply and rescale, for the previous P; every other request is settled without the
// multiplier. The next request is taken once the result sits in the output register, even
// while that result still waits for a transfer.
module pid_controller_antiwindup_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pidaw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  pidaw_pkg::pid_in_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output pidaw_pkg::pid_out_t             out_data
);
	import pidaw_pkg::*;

	pidaw_cmd_t         cmd;
	pidaw_stat_t        stat;
	logic               done;
	logic [1:0]         done_status;
	logic               out_free;
	logic signed [31:0] held_drive;
	logic               out_valid_q;
	pid_out_t           out_q;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	pidaw_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.out_free    (out_free),
		.stat        (stat),
		.cmd         (cmd),
		.done        (done),
		.done_status (done_status)
	);

	pidaw_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_data    (in_data),
		.cmd        (cmd),
		.stat       (stat),
		.held_drive (held_drive)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q.drive  <= held_drive;
			out_q.status <= done_status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`include "pid_controller_antiwindup_core_assert.svh"

	`PIDAW_ASSERT_IMPL(a_done_slot_free, clk, arst_n, done, out_free)
	`PIDAW_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`PIDAW_ASSERT_IMPL(a_no_update_holds, clk, arst_n, done && done_status != ST_OK, $stable(held_drive))

endmodule
